### hw/rtl/rkh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkh_pkg
// Shared types and constants for the recent key history list.
// ----------------------------------------------------------------------------
package rkh_pkg;

	localparam int DEPTH_DEF = 8;

	localparam int KIND_W     = 2;
	localparam int KEY_W      = 32;
	localparam int POSITION_W = 3;
	localparam int COUNT_W    = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// commands broadcast from the controller to every cell
	typedef struct packed {
		logic shift_down;
		logic shift_up;
	} cell_ctl_t;

endpackage

### hw/rtl/rkh_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkh_cell
// One list position: holds a key, compares it against the search key when
// the search token passes, and moves data to or from its neighbors.
// ----------------------------------------------------------------------------
module rkh_cell
	import rkh_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 4,
	parameter int PW  = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctl_t               ctl,
	input  logic signed [KEY_W-1:0] cmp_key,
	input  logic [CW-1:0]           count,
	input  logic signed [KEY_W-1:0] prev_entry,
	input  logic signed [KEY_W-1:0] next_entry,
	output logic signed [KEY_W-1:0] entry,
	input  logic                    tok_in,
	input  logic                    fnd_in,
	input  logic [PW-1:0]           pos_in,
	output logic                    tok_out,
	output logic                    fnd_out,
	output logic [PW-1:0]           pos_out
);

	logic signed [KEY_W-1:0] entry_q;
	logic                    tok_q;
	logic                    fnd_q;
	logic                    sh_q;
	logic [PW-1:0]           pos_q;
	logic                    hit;

	// only positions below the count hold live keys
	assign hit = (CW'(IDX) < count) && (entry_q == cmp_key);

	always_ff @(posedge clk) begin
		if (ctl.shift_down) begin
			entry_q <= prev_entry;
		end else if (ctl.shift_up && sh_q) begin
			entry_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
			fnd_q <= 1'b0;
			sh_q  <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (tok_in) begin
				fnd_q <= fnd_in | hit;
				// this cell and all behind the first match close the gap
				sh_q  <= fnd_in | hit;
			end
		end
	end

	// hold the first match position, else claim this one
	always_ff @(posedge clk) begin
		if (tok_in) begin
			pos_q <= fnd_in ? pos_in : PW'(IDX);
		end
	end

	assign entry   = entry_q;
	assign tok_out = tok_q;
	assign fnd_out = fnd_q;
	assign pos_out = pos_q;

endmodule

### hw/rtl/recent_key_history_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recent_key_history_list
// Ordered key history, newest at position 0, built as a row of cells.
// ----------------------------------------------------------------------------
// Insert, clear and the unused kind code act on the list when the beat is
// taken, and the result is registered and shown in the cycle after. A remove
// sends a search token down the row of cells, one cell per cycle, through the
// start flag and then each cell's token register in order, before the result
// registers take the outcome; no new beat is taken while the token walks.
// A new beat can be taken in the same cycle as the pending result. Insert into a
// full list drops the oldest key and flags it.
// ----------------------------------------------------------------------------
module recent_key_history_list
	import rkh_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [KIND_W-1:0]       kind,
	input  logic signed [KEY_W-1:0] key,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    found,
	output logic [POSITION_W-1:0]   position,
	output logic                    dropped,
	output logic [COUNT_W-1:0]      count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic signed [KEY_W-1:0] key_q;
	logic                    start_q;
	logic                    out_valid_q;
	logic                    found_q;
	logic [POSITION_W-1:0]   position_q;
	logic                    dropped_q;
	logic [COUNT_W-1:0]      count_q;

	logic                    accept;
	logic                    full;
	logic                    walk_done;
	cell_ctl_t               ctl;
	logic [CW-1:0]           cnt_next;
	logic [CW+COUNT_W-1:0]   cnt_ext;
	logic [PW+POSITION_W-1:0] pos_ext;

	logic signed [KEY_W-1:0] entry_w [DEPTH];
	logic [DEPTH-1:0]        tok_w;
	logic [DEPTH-1:0]        fnd_w;
	logic [PW-1:0]           pos_w [DEPTH];

	assign in_ready  = (state_q == ST_IDLE) || ((state_q == ST_RESP) && out_ready);
	assign accept    = in_valid && in_ready;
	assign full      = (cnt_q == CW'(DEPTH));
	assign walk_done = (state_q == ST_WALK) && tok_w[DEPTH-1];

	assign ctl.shift_down = accept && (kind == KIND_INSERT);
	assign ctl.shift_up   = walk_done && fnd_w[DEPTH-1];

	always_comb begin
		cnt_next = cnt_q;
		if (accept) begin
			case (kind)
				KIND_INSERT: cnt_next = full ? cnt_q : cnt_q + CW'(1);
				KIND_CLEAR:  cnt_next = '0;
				default:     cnt_next = cnt_q;
			endcase
		end else if (ctl.shift_up) begin
			cnt_next = cnt_q - CW'(1);
		end
	end

	assign cnt_ext = {{COUNT_W{1'b0}}, cnt_next};
	assign pos_ext = {{POSITION_W{1'b0}}, pos_w[DEPTH-1]};

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			rkh_cell #(
				.IDX (i),
				.CW  (CW),
				.PW  (PW)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.cmp_key    (key_q),
				.count      (cnt_q),
				.prev_entry ((i == 0) ? key : entry_w[(i == 0) ? 0 : i-1]),
				.next_entry (entry_w[(i == DEPTH-1) ? i : i+1]),
				.entry      (entry_w[i]),
				.tok_in     ((i == 0) ? start_q : tok_w[(i == 0) ? 0 : i-1]),
				.fnd_in     ((i == 0) ? 1'b0 : fnd_w[(i == 0) ? 0 : i-1]),
				.pos_in     ((i == 0) ? PW'(0) : pos_w[(i == 0) ? 0 : i-1]),
				.tok_out    (tok_w[i]),
				.fnd_out    (fnd_w[i]),
				.pos_out    (pos_w[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q   <= cnt_next;
			start_q <= accept && (kind == KIND_REMOVE);
			unique case (state_q) inside
				ST_IDLE, ST_RESP: begin
					if (accept) begin
						if (kind == KIND_REMOVE) begin
							state_q     <= ST_WALK;
							out_valid_q <= 1'b0;
						end else begin
							state_q     <= ST_RESP;
							out_valid_q <= 1'b1;
						end
					end else if (state_q == ST_RESP && out_ready) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				ST_WALK: begin
					if (walk_done) begin
						state_q     <= ST_RESP;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q      <= key;
			found_q    <= 1'b0;
			position_q <= '0;
			dropped_q  <= (kind == KIND_INSERT) && full;
			count_q    <= cnt_ext[COUNT_W-1:0];
		end else if (walk_done) begin
			found_q    <= fnd_w[DEPTH-1];
			position_q <= fnd_w[DEPTH-1] ? pos_ext[POSITION_W-1:0] : '0;
			dropped_q  <= 1'b0;
			count_q    <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;
	assign dropped   = dropped_q;
	assign count     = count_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_tok_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_w, start_q}))
		else $error("more than one search token in the chain");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_INSERT && full) |=> (out_valid && dropped))
		else $error("insert into full list did not flag a drop");

	a_walk_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_REMOVE) |=> (!out_valid && !in_ready))
		else $error("remove result shown before the search walk");

endmodule
